// File: sv/rclbf_pkg.sv
package rclbf_pkg;

  // Stick sample width and full-scale code of the stick converter.
  localparam int ADC_BITS = 12;
  localparam int ADC_MAX  = (1 << ADC_BITS) - 1;

  localparam int RAW_W  = 12;
  localparam int CH_W   = 11;
  localparam int PROD_W = RAW_W + 10;
  localparam int CNT_W  = 16;
  localparam int TIME_W = 32;

  // Channel constants.
  localparam logic [CH_W-1:0] CH_MIN    = 11'd1000;
  localparam logic [CH_W-1:0] CH_MAX    = 11'd2000;
  localparam logic [11:0]     PITCH_SUM = 12'd3000;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BELOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_BELOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAG_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd4;

  typedef struct packed {
    logic [RAW_W-1:0] cutoff_raw;
    logic [RAW_W-1:0] low_below_raw;
    logic [RAW_W-1:0] critical_below_raw;
    logic [CNT_W-1:0] sag_count_limit;
    logic [CNT_W-1:0] link_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic              send_ok;
    logic              ack_has_voltage;
    logic [RAW_W-1:0]  battery_raw;
    logic [TIME_W-1:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic crit_pre;   // critical flag before this tick's update
    logic low_flag;   // flags after this tick's update
    logic crit_flag;
    logic failsafe;
  } stat_t;

endpackage

// File: sv/rclbf_stick_map.sv
module rclbf_stick_map (
  input  logic [rclbf_pkg::RAW_W-1:0] raw,
  output logic [rclbf_pkg::CH_W-1:0]  mapped
);
  import rclbf_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] q_est;
  logic [PROD_W-1:0] q_times_max;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] quot;
  logic [PROD_W-1:0] sum;

  // Scale the sample by 1000.
  assign prod = PROD_W'(raw) * PROD_W'(1000);

  // Divide by 2^k-1: x/(2^k-1) is close to (x + x>>k) >> k from below,
  // never more than one short.
  assign q_est       = (prod + (prod >> ADC_BITS)) >> ADC_BITS;
  assign q_times_max = (q_est << ADC_BITS) - q_est;
  assign rem         = prod - q_times_max;
  assign quot        = (rem >= PROD_W'(ADC_MAX)) ? q_est + PROD_W'(1) : q_est;

  // Offset into the 1000..2000 channel range.
  assign sum    = quot + PROD_W'(CH_MIN);
  assign mapped = sum[CH_W-1:0];

endmodule

// File: sv/rclbf_link_mon.sv
module rclbf_link_mon (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  rclbf_pkg::tick_t  tick,
  input  rclbf_pkg::cfg_t   cfg,
  output rclbf_pkg::stat_t  stat
);
  import rclbf_pkg::*;

  logic [TIME_W-1:0] last_r, last_nxt;
  logic              fs_r, fs_nxt;
  logic [CNT_W-1:0]  low_cnt_r, low_cnt_nxt;
  logic [CNT_W-1:0]  crit_cnt_r, crit_cnt_nxt;
  logic              low_r, low_nxt;
  logic              crit_r, crit_nxt;

  logic              meas;
  logic              alive;
  logic              low_sag;
  logic              crit_sag;
  logic [CNT_W-1:0]  low_bump;
  logic [CNT_W-1:0]  crit_bump;
  logic [TIME_W-1:0] elapsed;
  logic              timeout;

  // Battery reading qualification.
  assign meas     = tick.send_ok && tick.ack_has_voltage;
  assign alive    = tick.battery_raw > cfg.cutoff_raw;
  assign low_sag  = tick.battery_raw < cfg.low_below_raw;
  assign crit_sag = tick.battery_raw < cfg.critical_below_raw;

  // Saturating increments of the sag counters.
  assign low_bump  = (low_cnt_r == '1) ? low_cnt_r : low_cnt_r + CNT_W'(1);
  assign crit_bump = (crit_cnt_r == '1) ? crit_cnt_r : crit_cnt_r + CNT_W'(1);

  // Link timer restarts on a good send; elapsed time wraps modulo 2^32.
  assign last_nxt = tick.send_ok ? tick.now_ms : last_r;
  assign elapsed  = tick.now_ms - last_nxt;
  assign timeout  = elapsed > TIME_W'(cfg.link_timeout_ms);

  // Next state: send handling, battery update, then the timeout check.
  always_comb begin
    fs_nxt       = tick.send_ok ? 1'b0 : fs_r;
    low_cnt_nxt  = low_cnt_r;
    crit_cnt_nxt = crit_cnt_r;
    low_nxt      = low_r;
    crit_nxt     = crit_r;
    if (meas && alive) begin
      if (low_sag) begin
        low_cnt_nxt = low_bump;
        if (low_bump >= cfg.sag_count_limit) begin
          low_nxt = 1'b1;
        end
      end else begin
        low_cnt_nxt = '0;
      end
      if (crit_sag) begin
        crit_cnt_nxt = crit_bump;
        if (crit_bump >= cfg.sag_count_limit) begin
          crit_nxt = 1'b1;
        end
      end else begin
        crit_cnt_nxt = '0;
      end
    end else if (meas) begin
      // A dead reading sets the low flag at once and leaves the counters.
      low_nxt = 1'b1;
    end
    if (timeout) begin
      fs_nxt       = 1'b1;
      low_nxt      = 1'b0;
      crit_nxt     = 1'b0;
      low_cnt_nxt  = '0;
      crit_cnt_nxt = '0;
    end
  end

  // State registers advance once per processed tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r     <= '0;
      fs_r       <= 1'b0;
      low_cnt_r  <= '0;
      crit_cnt_r <= '0;
      low_r      <= 1'b0;
      crit_r     <= 1'b0;
    end else if (fire) begin
      last_r     <= last_nxt;
      fs_r       <= fs_nxt;
      low_cnt_r  <= low_cnt_nxt;
      crit_cnt_r <= crit_cnt_nxt;
      low_r      <= low_nxt;
      crit_r     <= crit_nxt;
    end
  end

  assign stat.crit_pre  = crit_r;
  assign stat.low_flag  = low_nxt;
  assign stat.crit_flag = crit_nxt;
  assign stat.failsafe  = fs_nxt;

  // A good send always clears failsafe and restarts the timer.
  a_send_clears_fs: assert property (@(posedge clk) disable iff (!rst_n)
    fire && tick.send_ok |=> !fs_r && last_r == $past(tick.now_ms))
    else $error("send did not clear failsafe or restart the link timer");

  // A timeout leaves failsafe set with flags and counters cleared.
  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && timeout |=> fs_r && !low_r && !crit_r && low_cnt_r == '0 && crit_cnt_r == '0)
    else $error("timeout did not clear battery state");

  // A saturated counter that keeps sagging stays saturated.
  a_low_sat: assert property (@(posedge clk) disable iff (!rst_n)
    fire && low_cnt_r == '1 && meas && alive && low_sag && !timeout |=> low_cnt_r == '1)
    else $error("low sag counter wrapped");

endmodule

// File: sv/rc_link_battery_failsafe.sv
// An accepted transaction passes the input register and then the result register.
// Throughput: one transaction per cycle while out_tready does not stall the result;
// the stick mapping and the battery and link state update all fit between the input
// and result registers.
// Reset (rst_n low, synchronous): both stages empty, battery and link state
// cleared, configuration registers back to their default thresholds.
module rc_link_battery_failsafe (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // raw_throttle[11:0], raw_roll[23:12], raw_pitch[35:24], raw_yaw[47:36],
  // arm_pressed[48], aux_pressed[49], send_ok[50], ack_has_voltage[51],
  // battery_raw[63:52], now_ms[95:64]
  input  logic [95:0]                     in_tdata,
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // throttle_out[10:0], roll_out[21:11], pitch_out[32:22], yaw_out[43:33],
  // aux_out[54:44], arm_out[55], disarm_out[56], low_batt_led[57],
  // buzzer_on[58], failsafe_on[59], zero[63:60]
  output logic [63:0]                     out_tdata,
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rclbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rclbf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rclbf_pkg::*;

  logic        a_valid_r, a_valid_nxt;
  logic [95:0] a_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  cfg_t        cfg_r, cfg_nxt;

  logic        adv;
  logic        fire;
  tick_t       tick;
  stat_t       stat;

  logic [CH_W-1:0] thr_map, roll_map, pitch_map, yaw_map;
  logic [11:0]     pitch_diff;
  logic [CH_W-1:0] thr_out, pitch_out, aux_out;
  logic            arm_pressed, aux_pressed, arm_bit, buzzer;

  // Pipeline handshake: the result register frees when empty or taken.
  assign adv       = !out_valid_r || out_tready;
  assign fire      = a_valid_r && adv;
  assign in_tready = !a_valid_r || adv;
  assign a_valid_nxt   = in_tready ? in_tvalid : a_valid_r;
  assign out_valid_nxt = adv ? a_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_data_r <= in_tdata;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Configuration register file; writes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CUTOFF:     cfg_nxt.cutoff_raw         = cfg_data[RAW_W-1:0];
        REG_LOW_BELOW:  cfg_nxt.low_below_raw      = cfg_data[RAW_W-1:0];
        REG_CRIT_BELOW: cfg_nxt.critical_below_raw = cfg_data[RAW_W-1:0];
        REG_SAG_LIMIT:  cfg_nxt.sag_count_limit    = cfg_data[CNT_W-1:0];
        REG_TIMEOUT:    cfg_nxt.link_timeout_ms    = cfg_data[CNT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff_raw         <= 12'd2057;
      cfg_r.low_below_raw      <= 12'd2308;
      cfg_r.critical_below_raw <= 12'd2245;
      cfg_r.sag_count_limit    <= 16'd100;
      cfg_r.link_timeout_ms    <= 16'd500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Stick mapping, one converter per channel.
  rclbf_stick_map u_map_thr   (.raw(a_data_r[11:0]),  .mapped(thr_map));
  rclbf_stick_map u_map_roll  (.raw(a_data_r[23:12]), .mapped(roll_map));
  rclbf_stick_map u_map_pitch (.raw(a_data_r[35:24]), .mapped(pitch_map));
  rclbf_stick_map u_map_yaw   (.raw(a_data_r[47:36]), .mapped(yaw_map));

  // Battery and link supervision.
  assign tick.send_ok         = a_data_r[50];
  assign tick.ack_has_voltage = a_data_r[51];
  assign tick.battery_raw     = a_data_r[63:52];
  assign tick.now_ms          = a_data_r[95:64];

  rclbf_link_mon u_link_mon (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .tick (tick),
    .cfg  (cfg_r),
    .stat (stat)
  );

  // Result assembly; a critical flag from earlier ticks forces idle throttle and disarm.
  assign arm_pressed = a_data_r[48];
  assign aux_pressed = a_data_r[49];
  assign pitch_diff  = PITCH_SUM - {1'b0, pitch_map};
  assign pitch_out   = pitch_diff[CH_W-1:0];
  assign thr_out     = stat.crit_pre ? CH_MIN : thr_map;
  assign arm_bit     = arm_pressed && !stat.crit_pre;
  assign aux_out     = aux_pressed ? CH_MAX : CH_MIN;
  assign buzzer      = stat.crit_flag && arm_pressed && !stat.failsafe;

  assign out_data_nxt = {4'b0000, stat.failsafe, buzzer, stat.low_flag, !arm_bit, arm_bit,
                         aux_out, yaw_map, pitch_out, roll_map, thr_out};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A latched critical flag forces idle throttle and disarm on the next result.
  a_crit_forces: assert property (@(posedge clk) disable iff (!rst_n)
    fire && stat.crit_pre |=> out_tdata[10:0] == CH_MIN && !out_tdata[55] && out_tdata[56])
    else $error("critical flag did not force throttle and disarm");

  // In failsafe the battery indications are always off.
  a_fs_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[59] |-> !out_tdata[57] && !out_tdata[58])
    else $error("battery indication while in failsafe");

  // A stalled result transaction holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

endmodule
